>>> src/pgc_pkg.sv
// ----------------------------------------------------------------------------
// pgc_pkg: shared types and constants of the point grid collision check
// Fixed field widths, fixed-point shifts and the control and status records
// exchanged between the sequencer and the shared multiply-add unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pgc_pkg;

  // Field widths.
  localparam int GRID_W    = 16;   // grid position, signed Q12.4
  localparam int VOL_W     = 20;   // volume position, unsigned Q16.4
  localparam int PATCH_W   = 16;
  localparam int TRIG_W    = 16;   // signed Q1.14
  localparam int OFFS_W    = 20;   // signed Q16.4
  localparam int THR_W     = 16;
  localparam int CELL_W    = 10;   // width of the reported cell coordinates
  localparam int DSQ_W     = 42;
  localparam int CFG_W     = 20;   // configuration data, widest register
  localparam int CFG_IDX_W = 3;

  // Fixed-point alignment: Q.4 times Q1.14 gives Q.18.
  localparam int TRIG_SH   = 14;
  localparam int FRAC_W    = 18;
  localparam int THR_SH    = 8;    // whole voxels squared to 1/256 units

  // Shared unit widths.
  localparam int OPW  = 24;        // multiplier operands
  localparam int ACCW = 44;        // products, accumulator and adder

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATCH_ID  = 3'd0,
    REG_OFFSET_X  = 3'd1,
    REG_OFFSET_Y  = 3'd2,
    REG_COS_A     = 3'd3,
    REG_SIN_A     = 3'd4,
    REG_MIRROR    = 3'd5,
    REG_THRESHOLD = 3'd6
  } cfg_reg_t;

  // Control of the shared multiply-add unit for one cycle.
  typedef struct packed {
    logic signed [OPW-1:0]  mul_a;
    logic signed [OPW-1:0]  mul_b;
    logic signed [ACCW-1:0] k;        // constant or register operand
    logic                   use_acc;  // left adder input is acc, else zero
    logic                   y_prod;   // right adder input is product, else k
    logic                   sub;      // subtract right input
    logic                   acc_wr;   // write the sum into acc
    logic                   acc_cond; // write only when the sum is not negative
  } alu_ctl_t;

  // Status of the shared multiply-add unit.
  typedef struct packed {
    logic signed [ACCW-1:0] acc;
    logic signed [ACCW-1:0] prod;
    logic                   sum_neg;
    logic                   sum_zero;
  } alu_stat_t;

endpackage

`default_nettype wire

>>> src/point_grid_collision_check.sv
// ----------------------------------------------------------------------------
// point_grid_collision_check: maps mesh points to grid cells and checks overlap
// Scales, mirrors, rotates and translates each mesh point, divides it down to a
// grid cell and claims the cell or measures the distance to its stored point.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration is written through cfg_we, cfg_index and cfg_data while the
//   block is idle; each write takes effect at the clock edge it is sampled.
//   A point is accepted at a clock edge where start is high and busy is low.
//   One result per point is shown on the result ports for exactly one cycle,
//   marked by done; the receiver cannot hold it off.
//   Results per point: cell already occupied, cell empty, or out of range,
//   found either on the first coordinate or on the second.
//   A new point can be accepted in the done cycle, so one point is in work at
//   a time. All arithmetic runs on the single shared multiply-add unit: each
//   coordinate goes through rotation, rounding and the reciprocal multiply
//   that divides by the cell scale.
//   After reset the cell owner memory is cleared one entry per cycle, all
//   2^(2*C) entries with C = clog2(GRID_SIDE) (1048576 at the default
//   grid); busy stays high for that time. Configuration registers and the
//   running maximum are reset too.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module point_grid_collision_check import pgc_pkg::*; #(
  parameter int GRID_SIDE  = 1024,
  parameter int MESH_SCALE = 4,
  parameter int CELL_SCALE = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Configuration write port.
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]            cfg_data,
  // Command channel.
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic signed [GRID_W-1:0]    grid_x,
  input  wire logic signed [GRID_W-1:0]    grid_y,
  input  wire logic [VOL_W-1:0]            vol_x,
  input  wire logic [VOL_W-1:0]            vol_y,
  input  wire logic [VOL_W-1:0]            vol_z,
  // Result channel.
  output logic                             done,
  output logic [CELL_W-1:0]                cell_x,
  output logic [CELL_W-1:0]                cell_y,
  output logic                             out_of_range,
  output logic                             was_empty,
  output logic                             mismatch,
  output logic [PATCH_W-1:0]               other_patch,
  output logic [DSQ_W-1:0]                 distance_sq,
  output logic [DSQ_W-1:0]                 max_distance_sq
);

  // Derived sizes and constants.
  localparam int CW      = $clog2(GRID_SIDE);
  localparam int AW      = 2 * CW;
  // Quotients at or above 2^QW always leave the grid for cell scales up to 16.
  localparam int QW      = CW + 4;
  // Reciprocal of the cell scale, exact for every magnitude below 2^QW.
  localparam int RS      = QW + 4;
  localparam int RECIP   = ((1 << RS) + CELL_SCALE - 1) / CELL_SCALE;
  localparam int HALF_GS = GRID_SIDE / 2;
  localparam int HI_POS  = GRID_SIDE - HALF_GS;
  localparam int PT_W    = 3 * VOL_W;

  localparam logic signed [OPW-1:0]  MS_POS   = OPW'(MESH_SCALE);
  localparam logic signed [OPW-1:0]  MS_NEG   = -MS_POS;
  localparam logic signed [OPW-1:0]  RECIP_OP = OPW'(RECIP);
  localparam logic signed [ACCW-1:0] HALF_D   = ACCW'(CELL_SCALE) << (FRAC_W - 1);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_SCALE = 10'b00_0000_0100,
    S_ROT   = 10'b00_0000_1000,
    S_RND   = 10'b00_0001_0000,
    S_DIV   = 10'b00_0010_0000,
    S_CELL  = 10'b00_0100_0000,
    S_READ  = 10'b00_1000_0000,
    S_LOOK  = 10'b01_0000_0000,
    S_DIST  = 10'b10_0000_0000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [PATCH_W-1:0]        patch_id;
  logic signed [OFFS_W-1:0]  offset_x;
  logic signed [OFFS_W-1:0]  offset_y;
  logic signed [TRIG_W-1:0]  cos_a;
  logic signed [TRIG_W-1:0]  sin_a;
  logic                      mirror;
  logic [THR_W-1:0]          distance_threshold;

  // Latched point and working registers.
  logic signed [GRID_W-1:0]  in_gx;
  logic signed [GRID_W-1:0]  in_gy;
  logic [VOL_W-1:0]          in_vx;
  logic [VOL_W-1:0]          in_vy;
  logic [VOL_W-1:0]          in_vz;
  logic signed [OPW-1:0]     gx;
  logic signed [OPW-1:0]     gy;
  logic [2:0]                step;
  logic                      coord;
  logic                      neg;
  logic                      ovf;
  logic [QW-1:0]             quo;
  logic [CW-1:0]             cx;
  logic [CW-1:0]             cy;
  logic signed [VOL_W:0]     dx;
  logic signed [VOL_W:0]     dy;
  logic signed [VOL_W:0]     dz;
  logic [PATCH_W-1:0]        other;
  logic                      mis;
  logic [DSQ_W-1:0]          max_seen;
  logic [AW-1:0]             clr_addr;

  // Result registers.
  logic [CELL_W-1:0]         res_cx;
  logic [CELL_W-1:0]         res_cy;
  logic                      res_oor;
  logic                      res_empty;
  logic                      res_mis;
  logic [PATCH_W-1:0]        res_other;
  logic [DSQ_W-1:0]          res_dsq;

  // Shared unit and memories.
  alu_ctl_t                  ctl;
  alu_stat_t                 stat;
  logic                      own_we;
  logic [AW-1:0]             own_waddr;
  logic [PATCH_W-1:0]        own_wdata;
  logic [PATCH_W-1:0]        own_rdata;
  logic                      pt_we;
  logic [PT_W-1:0]           pt_rdata;
  logic [AW-1:0]             cell_addr;
  logic [QW:0]               cell_c;
  logic                      in_rng;
  logic                      cell_free;

  pgc_alu u_alu (
    .clk  (clk),
    .ctl  (ctl),
    .stat (stat)
  );

  // Cell owner memory, cleared after reset; holds patch number plus one.
  pgc_ram #(
    .WIDTH (PATCH_W),
    .DEPTH (1 << AW)
  ) u_owner_ram (
    .clk   (clk),
    .we    (own_we),
    .waddr (own_waddr),
    .wdata (own_wdata),
    .raddr (cell_addr),
    .rdata (own_rdata)
  );

  // Stored volume point of each claimed cell.
  pgc_ram #(
    .WIDTH (PT_W),
    .DEPTH (1 << AW)
  ) u_point_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (cell_addr),
    .wdata ({in_vx, in_vy, in_vz}),
    .raddr (cell_addr),
    .rdata (pt_rdata)
  );

  assign cell_addr = {cx, cy};
  assign cell_free = (own_rdata == '0);

  // Memory write control: clearing sweep, or claiming an empty cell.
  always_comb begin
    own_we    = 1'b0;
    own_waddr = cell_addr;
    own_wdata = patch_id + 1'b1;
    pt_we     = 1'b0;
    if (state == S_CLEAR) begin
      own_we    = 1'b1;
      own_waddr = clr_addr;
      own_wdata = '0;
    end else if (state == S_LOOK && cell_free) begin
      own_we = 1'b1;
      pt_we  = 1'b1;
    end
  end

  // Cell coordinate from the rounded quotient and its range check.
  always_comb begin
    if (neg) begin
      cell_c = (QW + 1)'(HALF_GS) - {1'b0, quo};
      in_rng = !ovf && ({1'b0, quo} <= (QW + 1)'(HALF_GS));
    end else begin
      cell_c = (QW + 1)'(HALF_GS) + {1'b0, quo};
      in_rng = !ovf && ({1'b0, quo} < (QW + 1)'(HI_POS));
    end
  end

  // Shared unit control for each step of the sequence.
  always_comb begin
    ctl = '0;
    unique case (state)
      S_SCALE: begin
        if (step == 3'd0) begin
          ctl.mul_a = OPW'(in_gx);
          ctl.mul_b = mirror ? MS_NEG : MS_POS;
        end else begin
          ctl.mul_a = OPW'(in_gy);
          ctl.mul_b = MS_POS;
        end
      end
      S_ROT: begin
        // x: gx*cos + gy*sin + offset_x;  y: gy*cos - gx*sin + offset_y
        ctl.mul_a = (step == 3'd0) ? (coord ? gy : gx) : (coord ? gx : gy);
        ctl.mul_b = (step == 3'd0) ? OPW'(cos_a) : OPW'(sin_a);
        ctl.acc_wr = 1'b1;
        if (step == 3'd0) begin
          ctl.k = coord ? (ACCW'(offset_y) <<< TRIG_SH) : (ACCW'(offset_x) <<< TRIG_SH);
        end else begin
          ctl.use_acc = 1'b1;
          ctl.y_prod  = 1'b1;
          ctl.sub     = (step == 3'd2) && coord;
        end
      end
      S_RND: begin
        // Negative values take the magnitude, others add half a divisor.
        ctl.acc_wr = 1'b1;
        if (stat.acc[ACCW-1]) begin
          ctl.k   = stat.acc;
          ctl.sub = 1'b1;
        end else begin
          ctl.k       = HALF_D;
          ctl.use_acc = 1'b1;
        end
      end
      S_DIV: begin
        // Whole plane units of the magnitude times the cell scale reciprocal.
        if (step == 3'd0) begin
          ctl.mul_a = OPW'({1'b0, stat.acc[FRAC_W +: QW]});
          ctl.mul_b = RECIP_OP;
        end
      end
      S_DIST: begin
        unique case (step)
          3'd0: begin
            ctl.mul_a = OPW'(dx);
            ctl.mul_b = OPW'(dx);
          end
          3'd1: begin
            ctl.mul_a  = OPW'(dy);
            ctl.mul_b  = OPW'(dy);
            ctl.y_prod = 1'b1;
            ctl.acc_wr = 1'b1;
          end
          3'd2: begin
            ctl.mul_a   = OPW'(dz);
            ctl.mul_b   = OPW'(dz);
            ctl.use_acc = 1'b1;
            ctl.y_prod  = 1'b1;
            ctl.acc_wr  = 1'b1;
          end
          3'd3: begin
            ctl.mul_a   = OPW'(distance_threshold);
            ctl.mul_b   = OPW'(distance_threshold);
            ctl.use_acc = 1'b1;
            ctl.y_prod  = 1'b1;
            ctl.acc_wr  = 1'b1;
          end
          3'd4: begin
            // Compare against the squared threshold in 1/256 units.
            ctl.k       = stat.prod <<< THR_SH;
            ctl.use_acc = 1'b1;
            ctl.sub     = 1'b1;
          end
          3'd5: begin
            // Compare against the running maximum.
            ctl.k       = ACCW'(max_seen);
            ctl.use_acc = 1'b1;
            ctl.sub     = 1'b1;
          end
          default: begin
            ctl = '0;
          end
        endcase
      end
      S_CLEAR, S_IDLE, S_CELL, S_READ, S_LOOK: begin
        ctl = '0;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      patch_id           <= '0;
      offset_x           <= '0;
      offset_y           <= '0;
      cos_a              <= TRIG_W'(16384);
      sin_a              <= '0;
      mirror             <= 1'b0;
      distance_threshold <= THR_W'(40);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATCH_ID:  patch_id           <= cfg_data[PATCH_W-1:0];
        REG_OFFSET_X:  offset_x           <= cfg_data[OFFS_W-1:0];
        REG_OFFSET_Y:  offset_y           <= cfg_data[OFFS_W-1:0];
        REG_COS_A:     cos_a              <= cfg_data[TRIG_W-1:0];
        REG_SIN_A:     sin_a              <= cfg_data[TRIG_W-1:0];
        REG_MIRROR:    mirror             <= cfg_data[0];
        REG_THRESHOLD: distance_threshold <= cfg_data[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
      max_seen <= '0;
      step     <= '0;
      coord    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (&clr_addr) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            in_gx <= grid_x;
            in_gy <= grid_y;
            in_vx <= vol_x;
            in_vy <= vol_y;
            in_vz <= vol_z;
            step  <= '0;
            coord <= 1'b0;
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          // Products arrive in the cycle after their operands.
          if (step == 3'd1) begin
            gx <= stat.prod[OPW-1:0];
          end
          if (step == 3'd2) begin
            gy    <= stat.prod[OPW-1:0];
            step  <= '0;
            state <= S_ROT;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_ROT: begin
          if (step == 3'd2) begin
            step  <= '0;
            state <= S_RND;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_RND: begin
          neg   <= stat.acc[ACCW-1];
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          // Magnitudes of 2^QW plane units or more are off the grid for cell scales up to 16.
          if (step == 3'd0) begin
            ovf  <= |stat.acc[ACCW-1:FRAC_W+QW];
            step <= step + 1'b1;
          end else begin
            quo   <= stat.prod[RS +: QW];
            step  <= '0;
            state <= S_CELL;
          end
        end
        S_CELL: begin
          if (!in_rng) begin
            // Outside the grid: report and leave the store untouched.
            res_cx    <= '0;
            res_cy    <= '0;
            res_oor   <= 1'b1;
            res_empty <= 1'b0;
            res_mis   <= 1'b0;
            res_other <= '0;
            res_dsq   <= '0;
            done      <= 1'b1;
            state     <= S_IDLE;
          end else if (!coord) begin
            cx    <= cell_c[CW-1:0];
            coord <= 1'b1;
            step  <= '0;
            state <= S_ROT;
          end else begin
            cy    <= cell_c[CW-1:0];
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_LOOK;
        end
        S_LOOK: begin
          if (cell_free) begin
            // Empty cell: claimed by the memory write this cycle.
            res_cx    <= CELL_W'(cx);
            res_cy    <= CELL_W'(cy);
            res_oor   <= 1'b0;
            res_empty <= 1'b1;
            res_mis   <= 1'b0;
            res_other <= '0;
            res_dsq   <= '0;
            done      <= 1'b1;
            state     <= S_IDLE;
          end else begin
            other <= own_rdata - 1'b1;
            dx    <= $signed({1'b0, pt_rdata[PT_W-1 -: VOL_W]}) - $signed({1'b0, in_vx});
            dy    <= $signed({1'b0, pt_rdata[2*VOL_W-1 -: VOL_W]}) - $signed({1'b0, in_vy});
            dz    <= $signed({1'b0, pt_rdata[VOL_W-1:0]}) - $signed({1'b0, in_vz});
            step  <= '0;
            state <= S_DIST;
          end
        end
        S_DIST: begin
          if (step == 3'd4) begin
            mis <= !stat.sum_neg && !stat.sum_zero;
          end
          if (step == 3'd5) begin
            if (!stat.sum_neg && !stat.sum_zero) begin
              max_seen <= stat.acc[DSQ_W-1:0];
            end
            res_cx    <= CELL_W'(cx);
            res_cy    <= CELL_W'(cy);
            res_oor   <= 1'b0;
            res_empty <= 1'b0;
            res_mis   <= mis;
            res_other <= other;
            res_dsq   <= stat.acc[DSQ_W-1:0];
            done      <= 1'b1;
            state     <= S_IDLE;
          end else begin
            step <= step + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Port drive.
  assign busy            = (state != S_IDLE);
  assign cell_x          = res_cx;
  assign cell_y          = res_cy;
  assign out_of_range    = res_oor;
  assign was_empty       = res_empty;
  assign mismatch        = res_mis;
  assign other_patch     = res_other;
  assign distance_sq     = res_dsq;
  assign max_distance_sq = max_seen;

endmodule

`default_nettype wire

>>> src/pgc_ram.sv
// ----------------------------------------------------------------------------
// pgc_ram: generic memory with one write port and one registered read port
// Write and read addresses are independent; read data appears in the cycle
// after the address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/pgc_alu.sv
// ----------------------------------------------------------------------------
// pgc_alu: shared multiply-add unit
// A registered signed multiplier feeding one wide adder and accumulator.
// The sequencer uses it for scaling, rotation, the reciprocal multiply of the
// cell division, the squared distance and the threshold and maximum compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgc_alu import pgc_pkg::*; (
  input  wire logic      clk,
  input  wire alu_ctl_t  ctl,
  output alu_stat_t      stat
);

  logic signed [2*OPW-1:0] prod_full;
  logic signed [ACCW-1:0]  prod;
  logic signed [ACCW-1:0]  acc;
  logic signed [ACCW-1:0]  add_x;
  logic signed [ACCW-1:0]  add_y;
  logic signed [ACCW-1:0]  sum;

  // Multiplier with its product registered before any use.
  assign prod_full = $signed(ctl.mul_a) * $signed(ctl.mul_b);

  always_ff @(posedge clk) begin
    prod <= ACCW'(prod_full);
  end

  // Adder: accumulator or zero, plus or minus the product or the k operand.
  always_comb begin
    add_x = ctl.use_acc ? acc : '0;
    add_y = ctl.y_prod ? prod : $signed(ctl.k);
    sum   = ctl.sub ? (add_x - add_y) : (add_x + add_y);
  end

  // Accumulator, optionally written only when the trial result is not negative.
  always_ff @(posedge clk) begin
    if (ctl.acc_wr && (!ctl.acc_cond || !sum[ACCW-1])) begin
      acc <= sum;
    end
  end

  assign stat.acc      = acc;
  assign stat.prod     = prod;
  assign stat.sum_neg  = sum[ACCW-1];
  assign stat.sum_zero = (sum == '0);

endmodule

`default_nettype wire

>>> src/pgc_checker.sv
// ----------------------------------------------------------------------------
// pgc_checker: port-level checks of the point grid collision check
// Watches the command and result ports and flags results that contradict
// each other or the sequencing of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgc_checker import pgc_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               done,
  input wire logic [CELL_W-1:0]  cell_x,
  input wire logic [CELL_W-1:0]  cell_y,
  input wire logic               out_of_range,
  input wire logic               was_empty,
  input wire logic               mismatch,
  input wire logic [PATCH_W-1:0] other_patch,
  input wire logic [DSQ_W-1:0]   distance_sq,
  input wire logic [DSQ_W-1:0]   max_distance_sq
);

  // An accepted transfer makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted transfer");

  // Results are single-cycle strobes; no two results come back to back.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // An out-of-range result carries no cell and no distance.
  a_oor_clean: assert property (@(posedge clk) disable iff (rst)
    (done && out_of_range) |-> (!was_empty && !mismatch && cell_x == '0 &&
      cell_y == '0 && other_patch == '0 && distance_sq == '0))
    else $error("out-of-range result with nonzero fields");

  // A newly claimed cell has no distance and no mismatch.
  a_empty_clean: assert property (@(posedge clk) disable iff (rst)
    (done && was_empty) |-> (!mismatch && distance_sq == '0 && other_patch == '0))
    else $error("claimed cell reports a distance");

  // The running maximum covers the distance just reported.
  a_max_cover: assert property (@(posedge clk) disable iff (rst)
    done |-> (max_distance_sq >= distance_sq))
    else $error("running maximum below reported distance");

endmodule

bind point_grid_collision_check pgc_checker u_pgc_checker (.*);

`default_nettype wire

>>> test/cell_collision_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_collision_monitor: result checker for the point grid collision check
// Follows register writes and accepted points, works out the grid cell and
// overlap result of every point with its own owner table, and compares each
// result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module cell_collision_monitor import pgc_pkg::*; #(
  parameter int GRID_SIDE  = 1024,
  parameter int MESH_SCALE = 4,
  parameter int CELL_SCALE = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     start,
  input  logic                     busy,
  input  logic signed [GRID_W-1:0] grid_x,
  input  logic signed [GRID_W-1:0] grid_y,
  input  logic [VOL_W-1:0]         vol_x,
  input  logic [VOL_W-1:0]         vol_y,
  input  logic [VOL_W-1:0]         vol_z,
  input  logic                     done,
  input  logic [CELL_W-1:0]        cell_x,
  input  logic [CELL_W-1:0]        cell_y,
  input  logic                     out_of_range,
  input  logic                     was_empty,
  input  logic                     mismatch,
  input  logic [PATCH_W-1:0]       other_patch,
  input  logic [DSQ_W-1:0]         distance_sq,
  input  logic [DSQ_W-1:0]         max_distance_sq,
  output int unsigned              pending,
  output int unsigned              errors,
  output int unsigned              checked,
  output int unsigned              claims,
  output int unsigned              overlaps,
  output int unsigned              over_limit,
  output int unsigned              outside
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE;

  typedef struct packed {
    logic [CELL_W-1:0]  cx;
    logic [CELL_W-1:0]  cy;
    logic               off_grid;
    logic               claimed;
    logic               flagged;
    logic [PATCH_W-1:0] other;
    logic [DSQ_W-1:0]   dsq;
    logic [DSQ_W-1:0]   peak;
  } cell_result_t;

  // Register copies.
  logic [PATCH_W-1:0]       patch_now;
  logic signed [OFFS_W-1:0] shift_x;
  logic signed [OFFS_W-1:0] shift_y;
  logic signed [TRIG_W-1:0] cos_now;
  logic signed [TRIG_W-1:0] sin_now;
  logic                     flip;
  logic [THR_W-1:0]         limit_now;

  // Cell store: owner code (0 means empty, else patch + 1) and the kept point.
  bit [PATCH_W-1:0]  owner_code [CELLS];
  bit [3*VOL_W-1:0]  kept_point [CELLS];
  logic [DSQ_W-1:0]  peak_dsq;

  cell_result_t predicted_cells [$];

  // Divide a Q.18 value down to whole cells: half up when not negative,
  // toward zero when negative.
  function automatic longint to_cell(input longint v);
    longint d;
    d = longint'(CELL_SCALE) <<< FRAC_W;
    if (v >= 0) return (v + d / 2) / d;
    return -((-v) / d);
  endfunction

  // Place one point on the grid and update the cell store.
  function automatic cell_result_t map_point(input logic signed [GRID_W-1:0] gx,
                                             input logic signed [GRID_W-1:0] gy,
                                             input logic [VOL_W-1:0] vx,
                                             input logic [VOL_W-1:0] vy,
                                             input logic [VOL_W-1:0] vz);
    longint px, py, rx, ry, cx, cy, dx, dy, dz, dsum;
    int key;
    logic [3*VOL_W-1:0] kept;
    cell_result_t r;
    r = '0;
    px = longint'(gx) * MESH_SCALE;
    py = longint'(gy) * MESH_SCALE;
    if (flip) px = -px;
    rx = px * cos_now + py * sin_now + (longint'(shift_x) <<< TRIG_SH);
    ry = py * cos_now - px * sin_now + (longint'(shift_y) <<< TRIG_SH);
    cx = to_cell(rx) + GRID_SIDE / 2;
    cy = to_cell(ry) + GRID_SIDE / 2;
    if (cx < 0 || cx >= GRID_SIDE || cy < 0 || cy >= GRID_SIDE) begin
      r.off_grid = 1'b1;
    end else begin
      key = int'(cx * GRID_SIDE + cy);
      r.cx = cx[CELL_W-1:0];
      r.cy = cy[CELL_W-1:0];
      if (owner_code[key] == '0) begin
        // Patch 65535 writes owner code zero, so the cell stays empty.
        r.claimed = 1'b1;
        owner_code[key] = patch_now + 1'b1;
        kept_point[key] = {vx, vy, vz};
      end else begin
        kept = kept_point[key];
        r.other = owner_code[key] - 1'b1;
        dx = longint'(kept[3*VOL_W-1:2*VOL_W]) - longint'(vx);
        dy = longint'(kept[2*VOL_W-1:VOL_W]) - longint'(vy);
        dz = longint'(kept[VOL_W-1:0]) - longint'(vz);
        dsum = dx * dx + dy * dy + dz * dz;
        r.dsq = dsum[DSQ_W-1:0];
        if (r.dsq > peak_dsq) peak_dsq = r.dsq;
        r.flagged = 64'(r.dsq) > (64'(limit_now) * 64'(limit_now)) << THR_SH;
      end
    end
    r.peak = peak_dsq;
    return r;
  endfunction

  // Count a wrong field and report the first few.
  task automatic compare_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("result %0d: %s expected %0d, got %0d", checked, what, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    cell_result_t want;
    cell_result_t r;
    if (rst) begin
      patch_now = '0;
      shift_x   = '0;
      shift_y   = '0;
      cos_now   = 16384;
      sin_now   = '0;
      flip      = 1'b0;
      limit_now = 40;
      peak_dsq  = '0;
      for (int i = 0; i < CELLS; i++) owner_code[i] = '0;
      predicted_cells.delete();
    end else begin
      // Result transfer: compare with the oldest prediction.
      if (done) begin
        if (predicted_cells.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result transfer with no point in flight");
        end else begin
          want = predicted_cells.pop_front();
          compare_field("cell_x", want.cx, cell_x);
          compare_field("cell_y", want.cy, cell_y);
          compare_field("out_of_range", want.off_grid, out_of_range);
          compare_field("was_empty", want.claimed, was_empty);
          compare_field("mismatch", want.flagged, mismatch);
          compare_field("other_patch", want.other, other_patch);
          compare_field("distance_sq", want.dsq, distance_sq);
          compare_field("max_distance_sq", want.peak, max_distance_sq);
          checked++;
        end
      end
      // Register writes.
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_PATCH_ID:  patch_now = cfg_data[PATCH_W-1:0];
          REG_OFFSET_X:  shift_x   = cfg_data[OFFS_W-1:0];
          REG_OFFSET_Y:  shift_y   = cfg_data[OFFS_W-1:0];
          REG_COS_A:     cos_now   = cfg_data[TRIG_W-1:0];
          REG_SIN_A:     sin_now   = cfg_data[TRIG_W-1:0];
          REG_MIRROR:    flip      = cfg_data[0];
          REG_THRESHOLD: limit_now = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      // Point transfer: predict its result.
      if (start && !busy) begin
        r = map_point(grid_x, grid_y, vol_x, vol_y, vol_z);
        if (r.off_grid) outside++;
        else if (r.claimed) claims++;
        else overlaps++;
        if (r.flagged) over_limit++;
        predicted_cells = {predicted_cells, r};
      end
    end
    pending <= predicted_cells.size();
  end

endmodule

>>> test/point_grid_collision_check_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_grid_collision_check_test: testbench of the point grid collision check
// Streams directed and random mesh points through several register settings,
// with random gaps and drains between bursts; a separate monitor predicts and
// checks every result, and a watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------

module point_grid_collision_check_test;
  import pgc_pkg::*;

  localparam int GRID_SIDE  = 1024;
  localparam int MESH_SCALE = 4;
  localparam int CELL_SCALE = 4;
  // The limit also covers the reset clearing pass, which has no transfers.
  localparam int unsigned QUIET_LIMIT = 4 * GRID_SIDE * GRID_SIDE + 100000;
  localparam int RANDOM_SETUPS = 12;
  localparam int POINTS_PER_SETUP = 66;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [GRID_W-1:0] grid_x = '0;
  logic signed [GRID_W-1:0] grid_y = '0;
  logic [VOL_W-1:0]         vol_x = '0;
  logic [VOL_W-1:0]         vol_y = '0;
  logic [VOL_W-1:0]         vol_z = '0;
  logic                     done;
  logic [CELL_W-1:0]        cell_x;
  logic [CELL_W-1:0]        cell_y;
  logic                     out_of_range;
  logic                     was_empty;
  logic                     mismatch;
  logic [PATCH_W-1:0]       other_patch;
  logic [DSQ_W-1:0]         distance_sq;
  logic [DSQ_W-1:0]         max_distance_sq;

  int unsigned pending, errors, checked, claims, overlaps, over_limit, outside;
  int unsigned points_sent = 0;
  int unsigned setups = 0;
  int unsigned quiet_cycles = 0;

  always #5 clk = ~clk;

  point_grid_collision_check #(
    .GRID_SIDE(GRID_SIDE), .MESH_SCALE(MESH_SCALE), .CELL_SCALE(CELL_SCALE)
  ) dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .start, .busy,
    .grid_x, .grid_y, .vol_x, .vol_y, .vol_z,
    .done, .cell_x, .cell_y, .out_of_range, .was_empty, .mismatch,
    .other_patch, .distance_sq, .max_distance_sq
  );

  cell_collision_monitor #(
    .GRID_SIDE(GRID_SIDE), .MESH_SCALE(MESH_SCALE), .CELL_SCALE(CELL_SCALE)
  ) u_monitor (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .start, .busy,
    .grid_x, .grid_y, .vol_x, .vol_y, .vol_z,
    .done, .cell_x, .cell_y, .out_of_range, .was_empty, .mismatch,
    .other_patch, .distance_sq, .max_distance_sq,
    .pending, .errors, .checked, .claims, .overlaps, .over_limit, .outside
  );

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Offer one point and return at the edge that accepts it; start stays high.
  task automatic send_point(input logic signed [GRID_W-1:0] gx,
                            input logic signed [GRID_W-1:0] gy,
                            input logic [VOL_W-1:0] vx,
                            input logic [VOL_W-1:0] vy,
                            input logic [VOL_W-1:0] vz);
    start  <= 1'b1;
    grid_x <= gx;
    grid_y <= gy;
    vol_x  <= vx;
    vol_y  <= vy;
    vol_z  <= vz;
    @(posedge clk);
    while (busy) @(posedge clk);
    points_sent++;
  endtask

  // Random idle time after a transfer, mostly short with a few long ones.
  task automatic idle_after(input bit steady);
    int unsigned r, gap;
    r = $urandom_range(0, 99);
    if (steady || r < 50) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 20);
    else gap = $urandom_range(30, 90);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every result has come back.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Write every register; the block must be idle.
  task automatic set_config(input logic [PATCH_W-1:0] patch,
                            input logic signed [OFFS_W-1:0] ox,
                            input logic signed [OFFS_W-1:0] oy,
                            input logic signed [TRIG_W-1:0] c,
                            input logic signed [TRIG_W-1:0] s,
                            input logic m,
                            input logic [THR_W-1:0] thr);
    write_reg(REG_PATCH_ID, CFG_W'(patch));
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_COS_A, CFG_W'(c));
    write_reg(REG_SIN_A, CFG_W'(s));
    write_reg(REG_MIRROR, CFG_W'(m));
    write_reg(REG_THRESHOLD, CFG_W'(thr));
    cfg_we <= 1'b0;
    setups++;
  endtask

  // Random register setting, extremes included now and then.
  task automatic random_config;
    logic [PATCH_W-1:0]       patch;
    logic signed [OFFS_W-1:0] ox, oy;
    logic signed [TRIG_W-1:0] c, s;
    logic [THR_W-1:0]         thr;
    int unsigned r;
    r = $urandom_range(0, 99);
    patch = (r < 8) ? 16'hFFFF : 16'($urandom_range(0, 65534));
    if ($urandom_range(0, 9) == 0) begin
      ox = OFFS_W'($urandom);
      oy = OFFS_W'($urandom);
    end else begin
      ox = OFFS_W'(int'($urandom_range(0, 600)) - 300);
      oy = OFFS_W'(int'($urandom_range(0, 600)) - 300);
    end
    case ($urandom_range(0, 5))
      0: begin c = 16384;  s = 0;      end
      1: begin c = 0;      s = 16384;  end
      2: begin c = -16384; s = 0;      end
      3: begin c = 0;      s = -16384; end
      4: begin c = 11585;  s = 11585;  end
      default: begin
        c = TRIG_W'(int'($urandom_range(0, 32768)) - 16384);
        s = TRIG_W'(int'($urandom_range(0, 32768)) - 16384);
      end
    endcase
    r = $urandom_range(0, 99);
    if (r < 10) thr = 0;
    else if (r < 20) thr = 16'hFFFF;
    else if (r < 30) thr = 16'($urandom);
    else thr = 16'($urandom_range(20, 60));
    set_config(patch, ox, oy, c, s, 1'($urandom_range(0, 1)), thr);
  endtask

  // Volume coordinate near a base, kept inside the field range.
  function automatic logic [VOL_W-1:0] near(input int base);
    int v;
    v = base + int'($urandom_range(0, 2000)) - 1000;
    if (v < 0) v = 0;
    if (v > 1048575) v = 1048575;
    return VOL_W'(v);
  endfunction

  initial begin : stimulus
    int kind, base_x, base_y, base_z;
    bit steady;
    logic signed [GRID_W-1:0] gx, gy;
    logic [VOL_W-1:0] vx, vy, vz;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // The owner table is cleared after reset; wait for that to finish.
    @(posedge clk);
    while (busy) @(posedge clk);

    // Plain setting: claim the center cell, then hit it far and near.
    set_config(16'd0, 0, 0, 16384, 0, 1'b0, 16'd40);
    send_point(0, 0, 0, 0, 0);
    send_point(0, 0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    send_point(0, 0, 20'd100, 20'd200, 20'd300);
    // Exact halves: positive rounds up, negative toward zero.
    send_point(16'sd8, -16'sd8, 20'd5, 20'd6, 20'd7);
    send_point(16'sd24, -16'sd24, 20'd5, 20'd6, 20'd7);
    // Last cells inside the grid, then the first ones outside.
    send_point(16'sd8176, -16'sd8192, 20'd9, 20'd9, 20'd9);
    send_point(16'sd8184, 16'sd0, 20'd9, 20'd9, 20'd9);
    send_point(16'sd0, -16'sd8208, 20'd9, 20'd9, 20'd9);
    send_point(-16'sd32768, -16'sd32768, 20'hFFFFF, 20'd0, 20'hFFFFF);
    send_point(16'sd32767, 16'sd32767, 20'd0, 20'hFFFFF, 20'd0);
    drain();

    // Patch 65535 wraps the owner code: the same cell reads empty twice.
    set_config(16'hFFFF, 0, 0, -16384, 16384, 1'b1, 16'd0);
    send_point(16'sd16, 16'sd16, 20'd1000, 20'd2000, 20'd3000);
    send_point(16'sd16, 16'sd16, 20'd4000, 20'd5000, 20'd6000);
    send_point(-16'sd32768, 16'sd32767, 20'd77, 20'd88, 20'd99);
    drain();

    // Extreme offsets push everything off the grid.
    set_config(16'd65534, -20'sd524288, 20'sd524287, 0, -16384, 1'b0, 16'd0);
    send_point(0, 0, 20'd1, 20'd1, 20'd1);
    drain();

    // Zero threshold: equal points pass, one unit apart mismatches.
    set_config(16'd65534, 20'sd100, -20'sd100, 16384, 0, 1'b0, 16'd0);
    send_point(0, 0, 20'd500, 20'd500, 20'd500);
    send_point(0, 0, 20'd500, 20'd500, 20'd500);
    send_point(0, 0, 20'd501, 20'd500, 20'd500);
    drain();

    // Largest threshold: the largest distance still mismatches.
    set_config(16'd7, 0, 0, 16384, 0, 1'b0, 16'hFFFF);
    send_point(0, 0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    drain();

    // Random setups, each streaming points mostly around the grid center.
    for (int p = 0; p < RANDOM_SETUPS; p++) begin
      random_config();
      steady = ($urandom_range(0, 2) == 0);
      base_x = $urandom_range(1000, 1047575);
      base_y = $urandom_range(1000, 1047575);
      base_z = $urandom_range(1000, 1047575);
      for (int i = 0; i < POINTS_PER_SETUP; i++) begin
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
          gx = GRID_W'(int'($urandom_range(0, 128)) - 64);
          gy = GRID_W'(int'($urandom_range(0, 128)) - 64);
          vx = near(base_x);
          vy = near(base_y);
          vz = near(base_z);
        end else if (kind < 85) begin
          gx = GRID_W'(int'($urandom_range(0, 16800)) - 8400);
          gy = GRID_W'(int'($urandom_range(0, 16800)) - 8400);
          vx = VOL_W'($urandom);
          vy = VOL_W'($urandom);
          vz = VOL_W'($urandom);
        end else begin
          gx = GRID_W'($urandom);
          gy = GRID_W'($urandom);
          vx = VOL_W'($urandom);
          vy = VOL_W'($urandom);
          vz = VOL_W'($urandom);
        end
        send_point(gx, gy, vx, vy, vz);
        // Now and then hold off until the block has emptied.
        if ($urandom_range(0, 49) == 0) drain();
        else idle_after(steady);
      end
      drain();
    end

    repeat (60) @(posedge clk);
    $display("%0d points over %0d register settings, %0d results checked",
             points_sent, setups, checked);
    $display("%0d cells claimed, %0d overlaps (%0d over threshold), %0d off the grid",
             claims, overlaps, over_limit, outside);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
